// File: sv/pri_pkg.sv
package pri_pkg;

   // State codes of the interlock machine, in walk order.
   localparam logic [2:0] ST_WAIT_LOW   = 3'd0;
   localparam logic [2:0] ST_WAIT_RGOOD = 3'd1;
   localparam logic [2:0] ST_WAIT_START = 3'd2;
   localparam logic [2:0] ST_WAIT_HIGH  = 3'd3;
   localparam logic [2:0] ST_ACTIVE     = 3'd4;

   // Flags carried by one request beat.
   typedef struct packed {
      logic rail_ok;
      logic interlock_ok;
      logic reset_req;
      logic start_in;
      logic session_dropped;
      logic permit_seen;
      logic reset_line_ok;
      logic watchdog_ok;
      logic session_new;
      logic frame_valid;
   } req_type;

   // Fields carried by one response beat.
   typedef struct packed {
      logic       drive_permit_low;
      logic       rearm_strobe;
      logic       heartbeat_strobe;
      logic [2:0] state_code;
   } rsp_type;

   // Machine state kept between ticks.
   typedef struct packed {
      logic [2:0] mode;
      logic       primed;
      logic       start_low_seen;
      logic       start_last;
      logic       link_ready;
   } state_type;

endpackage

// File: sv/pri_if.sv
// Request channel: one beat per control tick.
interface pri_req_if import pri_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// Response channel: one beat per accepted request.
interface pri_rsp_if import pri_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/pri_step.sv
module pri_step import pri_pkg::*; (
   input  state_type cur_state,
   input  req_type   req_data,
   output state_type next_state,
   output rsp_type   rsp_data
);

   // Return to wait-low: clear the session flags and sample the start level.
   function automatic state_type go_low(state_type st, logic level);
      state_type r;
      r                = st;
      r.mode           = ST_WAIT_LOW;
      r.start_low_seen = 1'b0;
      r.link_ready     = 1'b0;
      r.start_last     = level;
      return r;
   endfunction

   // One tick of the interlock machine.
   always_comb begin
      state_type s;
      logic      healthy;
      logic      rising;
      logic      rearm;
      logic      hb;
      s       = cur_state;
      healthy = req_data.rail_ok & req_data.interlock_ok;
      rising  = 1'b0;
      rearm   = 1'b0;

      // The first tick after reset counts as a reset event.
      if (!s.primed || req_data.reset_req) begin
         s        = go_low(s, req_data.start_in);
         s.primed = 1'b1;
      end

      if (!healthy || req_data.session_dropped) begin
         s = go_low(s, req_data.start_in);
      end else if (s.mode == ST_WAIT_LOW) begin
         if (!req_data.permit_seen) s.mode = ST_WAIT_RGOOD;
      end else if (s.mode == ST_WAIT_RGOOD) begin
         if (req_data.permit_seen) begin
            s = go_low(s, req_data.start_in);
         end else if (req_data.reset_line_ok) begin
            s.mode           = ST_WAIT_START;
            s.start_low_seen = ~req_data.start_in;
         end
      end else if (!req_data.reset_line_ok ||
                   (s.mode >= ST_WAIT_HIGH && !req_data.watchdog_ok)) begin
         s = go_low(s, req_data.start_in);
      end else if (s.mode == ST_ACTIVE && !req_data.permit_seen) begin
         s = go_low(s, req_data.start_in);
      end else if (s.mode == ST_WAIT_START) begin
         if (req_data.permit_seen) begin
            s = go_low(s, req_data.start_in);
         end else begin
            // A start edge counts only after a low level and a ready session.
            rising = req_data.start_in & ~s.start_last;
            if (req_data.session_new) s.link_ready = 1'b1;
            if (!req_data.start_in) s.start_low_seen = 1'b1;
            if (rising && s.start_low_seen && cur_state.link_ready &&
                req_data.watchdog_ok) begin
               rearm  = 1'b1;
               s.mode = ST_WAIT_HIGH;
            end
         end
      end else if (s.mode == ST_WAIT_HIGH) begin
         if (req_data.permit_seen) s.mode = ST_ACTIVE;
      end

      s.start_last = req_data.start_in;

      // The heartbeat needs the session ready both before and after the tick.
      hb = cur_state.link_ready & s.link_ready & healthy & req_data.reset_line_ok &
           req_data.frame_valid & (s.mode >= ST_WAIT_START) &
           ((s.mode == ST_ACTIVE) | ~req_data.permit_seen);

      next_state                = s;
      rsp_data.drive_permit_low = (s.mode == ST_WAIT_LOW);
      rsp_data.rearm_strobe     = rearm;
      rsp_data.heartbeat_strobe = hb;
      rsp_data.state_code       = s.mode;
   end

endmodule

// File: sv/permit_rearm_interlock_fsm_top.sv
// Latency: a response beat is valid in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle unless the sink stalls; the state register
// closes the only loop. A stalled response register still takes a new request when
// the sink drains it. Reset (synchronous, active high) puts the machine in wait-low
// and unprimed, so the first accepted beat acts as a reset event.
module permit_rearm_interlock_fsm_top import pri_pkg::*; (
   input logic       clock,
   input logic       reset,
   pri_req_if.sink   req_chan,
   pri_rsp_if.source rsp_chan
);

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      rsp_valid_ff;
   logic      accept;

   // Take a request whenever the response register is empty or being drained.
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   pri_step u_step (
      .cur_state  (state_ff),
      .req_data   (req_chan.data),
      .next_state (state_in),
      .rsp_data   (rsp_data_in)
   );

   // Machine state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Response register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // The reported state code tracks the state register it was taken from.
   a_code_matches_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_data_ff.state_code == state_ff.mode)
      else $error("response state code differs from machine state");

   // A rearm beat always lands in wait-high.
   a_rearm_to_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rearm_strobe |-> rsp_data_ff.state_code == ST_WAIT_HIGH)
      else $error("rearm strobe outside wait-high");

   // The permit-low request mirrors the wait-low state.
   a_permit_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.drive_permit_low ==
                       (rsp_data_ff.state_code == ST_WAIT_LOW))
      else $error("permit-low request disagrees with state code");

   // Any accepted beat primes the machine.
   a_primed: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff.primed)
      else $error("machine not primed after a beat");

   // Wait-low never leaves session flags set.
   a_low_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff.primed && state_ff.mode == ST_WAIT_LOW |->
         !state_ff.link_ready && !state_ff.start_low_seen)
      else $error("session flags set in wait-low");

endmodule
